FILE: design/vpld_pkg.sv
// Package for the versioned page LRU directory: sizes, codes and item types.
// Used by vpld_lru_order and the top module; depends on nothing.
`default_nettype none

package vpld_pkg;

    localparam int CAPACITY      = 16;
    localparam int SLOT_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int CFG_W         = 5;
    localparam int LIM_W         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLOT_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 5;
    localparam int KEY_W         = 256;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

    typedef enum logic {
        REQ_PUT = 1'b0,
        REQ_GET = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FAIL    = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type   req_type;
        logic [63:0] file_id_hi;
        logic [63:0] file_id_mid;
        logic [31:0] file_id_lo;
        logic [31:0] page_number;
        logic [31:0] lsn_file;
        logic [31:0] lsn_offset;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic                     evicted;
        logic [SLOT_FIELD_W-1:0]  evicted_slot;
        logic [COUNT_FIELD_W-1:0] entry_count_out;
    } t_result;

    typedef struct packed {
        logic [63:0] file_hi;
        logic [63:0] file_mid;
        logic [31:0] file_lo;
        logic [31:0] page;
        logic [63:0] lsn;
    } t_key;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] from;
        logic [SLOT_W-1:0] last;
        logic [SLOT_W-1:0] slot;
    } t_move_cmd;

endpackage

`default_nettype wire

FILE: design/vpld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the directory tags addressed by slot.
`default_nettype none

module vpld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/vpld_lru_order.sv
// LRU order list: slot numbers by position, least recent at position zero.
// Depends on vpld_pkg; moves one entry to a later position per command.
`default_nettype none

module vpld_lru_order
    import vpld_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SLOT_W-1:0] i_rd_pos,
    input  wire t_move_cmd         i_move,
    output logic      [SLOT_W-1:0] o_rd_slot,
    output logic      [SLOT_W-1:0] o_head_slot
);

    logic [SLOT_W-1:0] r_order [CAPACITY];
    logic [SLOT_W-1:0] n_order [CAPACITY];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_order[i] = r_order[i];
            if (i_move.en && SLOT_W'(i) == i_move.last) begin
                n_order[i] = i_move.slot;
            end else if (i_move.en && SLOT_W'(i) >= i_move.from &&
                         SLOT_W'(i) < i_move.last) begin
                n_order[i] = r_order[(i + 1) % CAPACITY];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_order[i] <= SLOT_W'(i);
            end
        end else begin
            r_order <= n_order;
        end
    end

    assign o_rd_slot   = r_order[i_rd_pos];
    assign o_head_slot = r_order[0];

endmodule

`default_nettype wire

FILE: design/versioned_page_lru_directory.sv
// Sequence: with entries present, the scan runs READ then CMP per LRU position from zero
// and stops at a hit; a get miss, an evicting put or a failed put ends in MISS, a put to a free slot in ALLOC.
// Throughput: one item at a time; busy holds until the result strobe, and the next
// item is taken in the strobe cycle. The scan reads one tag RAM entry per READ/CMP pair.
// Reset: entry count zero, LRU order slot 0..CAPACITY-1, limit 16; tags undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module versioned_page_lru_directory
    import vpld_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire t_req             i_req,
    output logic                  busy,
    output logic                  o_strobe,
    output t_result               o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CMP   = 5'b00100,
        S_MISS  = 5'b01000,
        S_ALLOC = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CFG_W-1:0]  r_max;
    t_key              r_key, n_key;
    t_req_type         r_req, n_req;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    t_move_cmd         move;
    logic [SLOT_W-1:0] lru_slot;
    logic [SLOT_W-1:0] head_slot;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_key              ram_rdata;
    t_key              key_in;
    logic              key_hit;
    logic [SLOT_W-1:0] last_pos;
    logic [LIM_W-1:0]  limit;
    logic              at_limit;

    function automatic t_result mk_result(t_status st, logic [SLOT_W-1:0] sl, logic ev,
                                          logic [SLOT_W-1:0] ev_sl, logic [CNT_W-1:0] cnt);
        t_result res;
        res.status          = st;
        res.slot            = SLOT_FIELD_W'(sl);
        res.evicted         = ev;
        res.evicted_slot    = SLOT_FIELD_W'(ev_sl);
        res.entry_count_out = COUNT_FIELD_W'(cnt);
        return res;
    endfunction

    vpld_lru_order u_order (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_pos    (r_pos),
        .i_move      (move),
        .o_rd_slot   (lru_slot),
        .o_head_slot (head_slot)
    );

    vpld_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_key),
        .i_raddr (lru_slot),
        .o_rdata (ram_rdata)
    );

    assign key_in.file_hi  = i_req.file_id_hi;
    assign key_in.file_mid = i_req.file_id_mid;
    assign key_in.file_lo  = i_req.file_id_lo;
    assign key_in.page     = i_req.page_number;
    assign key_in.lsn      = {i_req.lsn_file, i_req.lsn_offset};

    assign key_hit  = (ram_rdata == r_key);
    assign last_pos = SLOT_W'(r_count - CNT_W'(1));
    assign limit    = (LIM_W'(r_max) < LIM_W'(CAPACITY)) ? LIM_W'(r_max) : LIM_W'(CAPACITY);
    assign at_limit = (LIM_W'(r_count) >= limit);
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_count   = r_count;
        n_key     = r_key;
        n_req     = r_req;
        n_strobe  = 1'b0;
        n_result  = r_result;
        move      = '0;
        ram_we    = 1'b0;
        ram_waddr = lru_slot;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key   = key_in;
                    n_req   = i_req.req_type;
                    n_pos   = '0;
                    n_state = (r_count == '0) ? S_MISS : S_READ;
                end
            end
            S_READ: begin
                n_slot  = lru_slot;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (key_hit) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_req == REQ_GET) begin
                        move.en   = 1'b1;
                        move.from = r_pos;
                        move.last = last_pos;
                        move.slot = r_slot;
                        n_result  = mk_result(ST_OK, r_slot, 1'b0, '0, r_count);
                    end else begin
                        n_result  = mk_result(ST_PRESENT, r_slot, 1'b0, '0, r_count);
                    end
                end else if (r_pos == last_pos) begin
                    n_state = S_MISS;
                end else begin
                    n_pos   = r_pos + SLOT_W'(1);
                    n_state = S_READ;
                end
            end
            S_MISS: begin
                if (r_req == REQ_GET) begin
                    n_strobe = 1'b1;
                    n_result = mk_result(ST_MISS, '0, 1'b0, '0, r_count);
                    n_state  = S_IDLE;
                end else if (at_limit) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_count == '0) begin
                        n_result = mk_result(ST_FAIL, '0, 1'b0, '0, r_count);
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_slot;
                        move.en   = 1'b1;
                        move.from = '0;
                        move.last = last_pos;
                        move.slot = head_slot;
                        n_result  = mk_result(ST_OK, head_slot, 1'b1, head_slot, r_count);
                    end
                end else begin
                    n_pos   = SLOT_W'(r_count);
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                ram_we    = 1'b1;
                ram_waddr = lru_slot;
                n_count   = r_count + CNT_W'(1);
                n_strobe  = 1'b1;
                n_result  = mk_result(ST_OK, lru_slot, 1'b0, '0, r_count + CNT_W'(1));
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_count  <= '0;
            r_max    <= MAX_ENTRIES_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_key    <= n_key;
        r_req    <= n_req;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_result.status == ST_FAIL |-> r_count == '0 && !r_result.evicted)
        else $error("put failure with entries present");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_result.evicted |-> $stable(r_count) && r_result.status == ST_OK)
        else $error("eviction changed the entry count");

endmodule

`default_nettype wire
